// ===== src/lmap_pkg.sv =====
// ----------------------------------------------------------------------------
// lmap_pkg
// Types and fixed constants shared by the LED matrix animation player.
// ----------------------------------------------------------------------------
package lmap_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    FUNC_WR_PIXEL = 2'd0,
    FUNC_WR_DELAY = 2'd1,
    FUNC_RD_PIXEL = 2'd2,
    FUNC_ADVANCE  = 2'd3
  } lmap_func_e;

  // frame order; hold shows the frame without moving
  typedef enum logic [1:0] {
    MODE_FORWARD  = 2'd0,
    MODE_PINGPONG = 2'd1,
    MODE_RANDOM   = 2'd2,
    MODE_HOLD     = 2'd3
  } lmap_mode_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PIX_DATA,
    S_PIX_SCALE,
    S_ADV_SHOW,
    S_ADV_NEXT,
    S_RND_MUL,
    S_RND_RD,
    S_RND_CHK
  } lmap_state_e;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_LOOP_LIMIT = 2'd0;
  localparam logic [1:0] REG_RUN_MODE   = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

  localparam logic [7:0]  LOOP_LIMIT_RST = 8'd1;
  localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
  localparam logic [7:0]  LOOP_MAX       = 8'd255;
  localparam logic [15:0] LFSR_SEED      = 16'hACE1;
  localparam logic [4:0]  SHOWS_PER_LOOP = 5'd20;
  localparam logic [4:0]  RANDOM_LAST    = 5'd20;

  // floor(p*39/10000) == (p*SCALE_MUL) >> SCALE_SHIFT for p up to 255*255
  localparam logic [22:0] SCALE_MUL   = 23'd4187594;
  localparam int          SCALE_SHIFT = 30;

  typedef struct packed {
    lmap_func_e  func;
    logic [3:0]  frame_index;
    logic [3:0]  column;
    logic [3:0]  row;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] delay_in;
  } lmap_item_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        running;
    logic [15:0] shown_delay;
    logic [3:0]  next_frame;
  } lmap_result_t;

  typedef struct packed {
    logic [7:0] loop_limit;
    lmap_mode_e run_mode;
    logic [7:0] brightness;
  } lmap_cfg_t;

endpackage

// ===== src/lmap_regs.sv =====
// ----------------------------------------------------------------------------
// lmap_regs
// APB-style configuration registers: loop limit, run mode and brightness.
// ----------------------------------------------------------------------------
module lmap_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o,
  output lmap_pkg::lmap_cfg_t cfg_o
);

  lmap_pkg::lmap_cfg_t cfg_q;
  logic                wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_limit <= lmap_pkg::LOOP_LIMIT_RST;
      cfg_q.run_mode   <= lmap_pkg::MODE_FORWARD;
      cfg_q.brightness <= lmap_pkg::BRIGHTNESS_RST;
    end else if (wr_en) begin
      case (paddr_i[3:2])
        lmap_pkg::REG_LOOP_LIMIT: cfg_q.loop_limit <= pwdata_i[7:0];
        lmap_pkg::REG_RUN_MODE:   cfg_q.run_mode   <= lmap_pkg::lmap_mode_e'(pwdata_i[1:0]);
        lmap_pkg::REG_BRIGHTNESS: cfg_q.brightness <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr_i[3:2])
      lmap_pkg::REG_LOOP_LIMIT: prdata_o = 32'(cfg_q.loop_limit);
      lmap_pkg::REG_RUN_MODE:   prdata_o = 32'(cfg_q.run_mode);
      lmap_pkg::REG_BRIGHTNESS: prdata_o = 32'(cfg_q.brightness);
      default:                  prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/lmap_pixel_mem.sv =====
// ----------------------------------------------------------------------------
// lmap_pixel_mem
// Single-port-per-direction pixel colour RAM with registered read data.
// ----------------------------------------------------------------------------
module lmap_pixel_mem #(
  parameter int DEPTH  = 1760,
  parameter int ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [23:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [23:0]       rdata_o
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lmap_delay_mem.sv =====
// ----------------------------------------------------------------------------
// lmap_delay_mem
// Frame delay RAM; per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module lmap_delay_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [15:0]      rdata_q;

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // data write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, zero for entries never written
  always_ff @(posedge clk_i) begin
    rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : 16'd0;
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lmap_scaler.sv =====
// ----------------------------------------------------------------------------
// lmap_scaler
// Brightness scaling of three colour channels: registered channel*brightness
// product, then a reciprocal multiply for the fixed 39/10000 factor.
// ----------------------------------------------------------------------------
module lmap_scaler (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [23:0] pixel_i,
  input  logic [7:0]  brightness_i,
  output logic [23:0] scaled_o
);

  logic [15:0] prod_q [3];
  logic [38:0] fix    [3];

  // first stage: channel times brightness
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= 16'(pixel_i[ch*8 +: 8]) * 16'(brightness_i);
      end
    end
  end

  // second stage: constant factor by reciprocal
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      fix[ch] = 39'(prod_q[ch]) * 39'(lmap_pkg::SCALE_MUL);
      scaled_o[ch*8 +: 8] = fix[ch][lmap_pkg::SCALE_SHIFT +: 8];
    end
  end

endmodule

// ===== src/led_matrix_animation_player.sv =====
// ----------------------------------------------------------------------------
// led_matrix_animation_player
// Multi-frame animation player for an LED matrix, built around a pixel RAM
// and a frame delay RAM driven by a small sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on result_o for a single cycle with result_valid_o, and busy drops in that
// same cycle so the next item can go in. Writes end in S_EXEC; a pixel read
// adds S_PIX_DATA and S_PIX_SCALE (RAM read, then the two scaling stages);
// an advance ends in S_EXEC when the animation is done, in S_ADV_SHOW for
// forward or ping-pong at a wrap past the last frame and for hold, else in
// S_ADV_NEXT (two delay RAM reads in turn). A random advance loops S_RND_MUL,
// S_RND_RD and S_RND_CHK for 1 to 21 tries: each shifts the LFSR, reduces it
// modulo the frame count through a reciprocal multiply and reads the delay
// RAM. Valid bits clear the delay store at reset, with no clearing pass.
// ----------------------------------------------------------------------------
module led_matrix_animation_player #(
  parameter int FRAME_COUNT    = 16,
  parameter int MATRIX_COLUMNS = 11,
  parameter int MATRIX_ROWS    = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  lmap_pkg::lmap_item_t   item_i,
  output logic                   result_valid_o,
  output lmap_pkg::lmap_result_t result_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CF_W          = $clog2(FRAME_COUNT);
  localparam int NF_W          = CF_W + 1;
  localparam int PIX_PER_FRAME = MATRIX_COLUMNS * MATRIX_ROWS;
  localparam int PIX_TOTAL     = FRAME_COUNT * PIX_PER_FRAME;
  localparam int PA_W          = $clog2(PIX_TOTAL);
  localparam logic [23:0] RECIP = 24'((32'd1 << 24) / FRAME_COUNT);

  lmap_pkg::lmap_cfg_t    cfg;
  lmap_pkg::lmap_state_e  state_q, state_d;
  lmap_pkg::lmap_item_t   req_q, req_d;
  lmap_pkg::lmap_result_t res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  logic [CF_W-1:0] cf_q, cf_d;
  logic [7:0]      loop_q, loop_d;
  logic            dir_q, dir_d;
  logic [4:0]      rsc_q, rsc_d;
  logic [15:0]     lfsr_q, lfsr_d;
  logic [4:0]      tries_q, tries_d;
  logic [NF_W-1:0] nf_q, nf_d;
  logic [15:0]     shown_q, shown_d;
  logic [15:0]     quot_q, quot_d;
  logic [CF_W-1:0] cand_q, cand_d;

  logic            accept;
  logic            pos_ok, frame_ok, adv_done, adv_wrap, rnd_stop;
  logic [NF_W-1:0] adv_nf;
  logic [NF_W-1:0] fin_in, fin_nf;
  logic            fin_ends, fin_dir;
  logic [7:0]      fin_loop;
  logic [15:0]     lfsr_next;
  logic [39:0]     recip_prod;
  logic [22:0]     quot_back, rem_raw, rem_fix;
  logic [CF_W-1:0] rem;

  logic            pix_we, pix_re, dly_we, scale_load;
  logic [PA_W-1:0] pix_waddr, pix_raddr;
  logic [23:0]     pix_rdata, scaled;
  logic [CF_W-1:0] dly_waddr, dly_raddr;
  logic [15:0]     dly_rdata;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == lmap_pkg::LOOP_MAX) ? v : v + 8'd1;
  endfunction

  // configuration port
  lmap_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // pixel store
  lmap_pixel_mem #(
    .DEPTH  (PIX_TOTAL),
    .ADDR_W (PA_W)
  ) u_pixel_mem (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i ({req_q.red_in, req_q.green_in, req_q.blue_in}),
    .re_i    (pix_re),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  // delay store
  lmap_delay_mem #(
    .DEPTH  (FRAME_COUNT),
    .ADDR_W (CF_W)
  ) u_delay_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (req_q.delay_in),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  // brightness scaling
  lmap_scaler u_scaler (
    .clk_i        (clk_i),
    .load_i       (scale_load),
    .pixel_i      (pix_rdata),
    .brightness_i (cfg.brightness),
    .scaled_o     (scaled)
  );

  assign accept = start & ~busy;
  assign busy   = (state_q != lmap_pkg::S_IDLE);

  // bounds and addresses
  assign pos_ok   = (6'(req_q.column) < 6'(MATRIX_COLUMNS)) &&
                    (6'(req_q.row) < 6'(MATRIX_ROWS));
  assign frame_ok = 7'(req_q.frame_index) < 7'(FRAME_COUNT);
  assign pix_waddr = PA_W'(32'(req_q.frame_index) * 32'(PIX_PER_FRAME) +
                           32'(req_q.row) * 32'(MATRIX_COLUMNS) + 32'(req_q.column));
  assign pix_raddr = PA_W'(32'(cf_q) * 32'(PIX_PER_FRAME) +
                           32'(req_q.row) * 32'(MATRIX_COLUMNS) + 32'(req_q.column));
  assign dly_waddr = CF_W'(req_q.frame_index);

  // advance decisions
  assign adv_done = loop_q >= cfg.loop_limit;
  always_comb begin
    if (cfg.run_mode == lmap_pkg::MODE_PINGPONG && dir_q) begin
      adv_nf = (cf_q != '0) ? NF_W'(cf_q) - NF_W'(1) : '0;
    end else begin
      adv_nf = NF_W'(cf_q) + NF_W'(1);
    end
  end
  assign adv_wrap = adv_nf >= NF_W'(FRAME_COUNT);

  // end-of-sequence handling for forward and ping-pong
  always_comb begin
    fin_in   = (state_q == lmap_pkg::S_ADV_SHOW) ? adv_nf : nf_q;
    fin_ends = (state_q == lmap_pkg::S_ADV_SHOW) ? 1'b1 : (dly_rdata == 16'd0);
    fin_nf   = fin_in;
    fin_dir  = dir_q;
    fin_loop = loop_q;
    if (cfg.run_mode == lmap_pkg::MODE_FORWARD) begin
      if (fin_ends) begin
        fin_nf   = '0;
        fin_loop = sat_inc(fin_loop);
      end
    end else begin
      if (fin_ends) begin
        fin_dir  = 1'b1;
        fin_nf   = (fin_nf >= NF_W'(2)) ? fin_nf - NF_W'(2) : '0;
        fin_loop = sat_inc(fin_loop);
      end
      if (fin_nf == '0) begin
        fin_dir  = 1'b0;
        fin_loop = sat_inc(fin_loop);
      end
    end
  end

  // random candidate: lfsr shift, reciprocal quotient, remainder fix-up
  assign lfsr_next  = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign recip_prod = 40'(lfsr_next) * 40'(RECIP);
  assign quot_back  = 23'(quot_q) * 23'(FRAME_COUNT);
  assign rem_raw    = 23'(lfsr_q) - quot_back;
  assign rem_fix    = (rem_raw >= 23'(FRAME_COUNT)) ? rem_raw - 23'(FRAME_COUNT) : rem_raw;
  assign rem        = CF_W'(rem_fix);
  assign rnd_stop   = (dly_rdata != 16'd0) || (tries_q == lmap_pkg::RANDOM_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lmap_pkg::S_IDLE: begin
        if (accept) state_d = lmap_pkg::S_EXEC;
      end
      lmap_pkg::S_EXEC: begin
        state_d = lmap_pkg::S_IDLE;
        if (req_q.func == lmap_pkg::FUNC_RD_PIXEL && pos_ok) begin
          state_d = lmap_pkg::S_PIX_DATA;
        end else if (req_q.func == lmap_pkg::FUNC_ADVANCE && !adv_done) begin
          state_d = lmap_pkg::S_ADV_SHOW;
        end
      end
      lmap_pkg::S_PIX_DATA:  state_d = lmap_pkg::S_PIX_SCALE;
      lmap_pkg::S_PIX_SCALE: state_d = lmap_pkg::S_IDLE;
      lmap_pkg::S_ADV_SHOW: begin
        case (cfg.run_mode)
          lmap_pkg::MODE_FORWARD,
          lmap_pkg::MODE_PINGPONG: state_d = adv_wrap ? lmap_pkg::S_IDLE : lmap_pkg::S_ADV_NEXT;
          lmap_pkg::MODE_RANDOM:   state_d = lmap_pkg::S_RND_MUL;
          default:                 state_d = lmap_pkg::S_IDLE;
        endcase
      end
      lmap_pkg::S_ADV_NEXT: state_d = lmap_pkg::S_IDLE;
      lmap_pkg::S_RND_MUL:  state_d = lmap_pkg::S_RND_RD;
      lmap_pkg::S_RND_RD:   state_d = lmap_pkg::S_RND_CHK;
      lmap_pkg::S_RND_CHK:  state_d = rnd_stop ? lmap_pkg::S_IDLE : lmap_pkg::S_RND_MUL;
      default:              state_d = lmap_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d       = req_q;
    cf_d        = cf_q;
    loop_d      = loop_q;
    dir_d       = dir_q;
    rsc_d       = rsc_q;
    lfsr_d      = lfsr_q;
    tries_d     = tries_q;
    nf_d        = nf_q;
    shown_d     = shown_q;
    quot_d      = quot_q;
    cand_d      = cand_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    pix_we      = 1'b0;
    pix_re      = 1'b0;
    dly_we      = 1'b0;
    dly_raddr   = cf_q;
    scale_load  = 1'b0;
    case (state_q)
      lmap_pkg::S_IDLE: begin
        if (accept) req_d = item_i;
      end
      lmap_pkg::S_EXEC: begin
        case (req_q.func)
          lmap_pkg::FUNC_WR_PIXEL: begin
            pix_we      = pos_ok && frame_ok;
            res_valid_d = 1'b1;
          end
          lmap_pkg::FUNC_WR_DELAY: begin
            dly_we      = frame_ok;
            res_valid_d = 1'b1;
          end
          lmap_pkg::FUNC_RD_PIXEL: begin
            pix_re      = pos_ok;
            res_valid_d = !pos_ok;
          end
          lmap_pkg::FUNC_ADVANCE: begin
            // first advance of a run starts upward
            if (cf_q == '0 && loop_q == 8'd0 &&
                (cfg.run_mode == lmap_pkg::MODE_FORWARD ||
                 cfg.run_mode == lmap_pkg::MODE_PINGPONG)) begin
              dir_d = 1'b0;
            end
            if (adv_done) begin
              cf_d        = '0;
              loop_d      = 8'd0;
              dir_d       = 1'b0;
              rsc_d       = 5'd0;
              res_valid_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      lmap_pkg::S_PIX_DATA: begin
        scale_load = 1'b1;
      end
      lmap_pkg::S_PIX_SCALE: begin
        res_valid_d     = 1'b1;
        res_d.red_out   = scaled[23:16];
        res_d.green_out = scaled[15:8];
        res_d.blue_out  = scaled[7:0];
      end
      lmap_pkg::S_ADV_SHOW: begin
        shown_d = dly_rdata;
        case (cfg.run_mode)
          lmap_pkg::MODE_FORWARD,
          lmap_pkg::MODE_PINGPONG: begin
            if (adv_wrap) begin
              cf_d              = CF_W'(fin_nf);
              loop_d            = fin_loop;
              dir_d             = fin_dir;
              res_valid_d       = 1'b1;
              res_d.running     = 1'b1;
              res_d.shown_delay = dly_rdata;
            end else begin
              nf_d      = adv_nf;
              dly_raddr = CF_W'(adv_nf);
            end
          end
          lmap_pkg::MODE_RANDOM: begin
            rsc_d   = rsc_q + 5'd1;
            tries_d = 5'd0;
          end
          default: begin
            res_valid_d       = 1'b1;
            res_d.running     = 1'b1;
            res_d.shown_delay = dly_rdata;
          end
        endcase
      end
      lmap_pkg::S_ADV_NEXT: begin
        cf_d              = CF_W'(fin_nf);
        loop_d            = fin_loop;
        dir_d             = fin_dir;
        res_valid_d       = 1'b1;
        res_d.running     = 1'b1;
        res_d.shown_delay = shown_q;
      end
      lmap_pkg::S_RND_MUL: begin
        lfsr_d = lfsr_next;
        quot_d = recip_prod[39:24];
      end
      lmap_pkg::S_RND_RD: begin
        cand_d    = rem;
        dly_raddr = rem;
      end
      lmap_pkg::S_RND_CHK: begin
        if (rnd_stop) begin
          cf_d = cand_q;
          if (rsc_q >= lmap_pkg::SHOWS_PER_LOOP) begin
            rsc_d  = 5'd0;
            loop_d = sat_inc(loop_q);
          end
          res_valid_d       = 1'b1;
          res_d.running     = 1'b1;
          res_d.shown_delay = shown_q;
        end else begin
          tries_d = tries_q + 5'd1;
        end
      end
      default: ;
    endcase
    res_d.next_frame = 4'(cf_d);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmap_pkg::S_IDLE;
      cf_q        <= '0;
      loop_q      <= 8'd0;
      dir_q       <= 1'b0;
      rsc_q       <= 5'd0;
      lfsr_q      <= lmap_pkg::LFSR_SEED;
      tries_q     <= 5'd0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cf_q        <= cf_d;
      loop_q      <= loop_d;
      dir_q       <= dir_d;
      rsc_q       <= rsc_d;
      lfsr_q      <= lfsr_d;
      tries_q     <= tries_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    nf_q    <= nf_d;
    shown_q <= shown_d;
    quot_q  <= quot_d;
    cand_q  <= cand_d;
    res_q   <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // checks
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy low after an accepted transaction");

  a_result_from_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) != lmap_pkg::S_IDLE)
    else $error("result strobe without a transaction in progress");

  a_frame_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cf_q) < 32'(FRAME_COUNT))
    else $error("current frame out of range");

  a_show_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsc_q <= lmap_pkg::SHOWS_PER_LOOP)
    else $error("random show count beyond one loop");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED matrix animation player. A generator fills
// a command queue; every command carries the report that a software copy of
// the player predicts for it, computed in issue order. A negedge driver
// offers commands on the start/busy handshake with random gaps, and a posedge
// monitor checks each report against the oldest prediction. Registers are
// written over APB between phases, with a read back of each one.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAMES        = 16;
  localparam int COLS          = 11;
  localparam int ROWS          = 10;
  localparam int PIX_PER_FRAME = COLS * ROWS;
  localparam int PIXELS        = FRAMES * PIX_PER_FRAME;
  localparam int TRIES         = 21;
  localparam int ITEM_TARGET   = 1300;
  localparam int CALM_FROM     = 1150;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // one queued command with the report predicted for it
  typedef struct packed {
    lmap_pkg::lmap_item_t   item;
    lmap_pkg::lmap_result_t report;
  } player_cmd_t;

  logic                   clk_i;
  logic                   rst_ni  = 1'b0;
  logic                   start   = 1'b0;
  logic                   busy;
  lmap_pkg::lmap_item_t   item_i  = '0;
  logic                   result_valid_o;
  lmap_pkg::lmap_result_t result_o;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [3:0]             paddr   = '0;
  logic [31:0]            pwdata  = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // software copy of the player
  logic [15:0]          delay_mem [FRAMES];
  logic [23:0]          pixel_mem [PIXELS];
  bit                   pixel_set [PIXELS];
  logic [4:0]           frame_now      = '0;
  logic [7:0]           loops_done     = '0;
  bit                   going_down     = 1'b0;
  logic [4:0]           random_shows   = '0;
  logic [15:0]          lfsr           = lmap_pkg::LFSR_SEED;
  logic [7:0]           cfg_loop_limit = lmap_pkg::LOOP_LIMIT_RST;
  lmap_pkg::lmap_mode_e cfg_mode       = lmap_pkg::MODE_FORWARD;
  logic [7:0]           cfg_bright     = lmap_pkg::BRIGHTNESS_RST;

  // command flow and checking
  player_cmd_t            cmd_queue [$];
  lmap_pkg::lmap_result_t expected_reports [$];
  player_cmd_t            next_cmd;
  lmap_pkg::lmap_result_t offered_report = '0;
  lmap_pkg::lmap_result_t want;
  int                     queued_total = 0;
  int                     reports_seen = 0;
  int                     errors       = 0;
  int                     quiet_cycles = 0;
  int                     idle_pct     = 0;
  int                     gap_left     = 0;
  bit                     taken_q      = 1'b0;

  led_matrix_animation_player u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // brightness scaling of one channel
  function automatic logic [7:0] dim(input logic [7:0] c);
    int unsigned a;
    int unsigned b;
    a = c;
    b = cfg_bright;
    return 8'((a * b * 39) / 10000);
  endfunction

  // a step lands past the last frame or on a zero delay
  function automatic bit seq_end(input logic [4:0] f);
    return f >= FRAMES || delay_mem[f[3:0]] == 16'd0;
  endfunction

  function automatic void bump_loop();
    if (loops_done != lmap_pkg::LOOP_MAX) loops_done++;
  endfunction

  // predicted report of one command, updating the software copy
  function automatic lmap_pkg::lmap_result_t play_step(input lmap_pkg::lmap_item_t it);
    lmap_pkg::lmap_result_t r;
    logic [4:0]             nf;
    logic [23:0]            c;
    int                     px;
    bit                     pos_ok;
    r = '0;
    pos_ok = it.column < COLS && it.row < ROWS;
    px = it.row * COLS + it.column;
    case (it.func)
      lmap_pkg::FUNC_WR_PIXEL: begin
        if (pos_ok) begin
          pixel_mem[it.frame_index * PIX_PER_FRAME + px] = {it.red_in, it.green_in, it.blue_in};
          pixel_set[it.frame_index * PIX_PER_FRAME + px] = 1'b1;
        end
      end
      lmap_pkg::FUNC_WR_DELAY: begin
        delay_mem[it.frame_index] = it.delay_in;
      end
      lmap_pkg::FUNC_RD_PIXEL: begin
        if (pos_ok) begin
          c = pixel_mem[frame_now * PIX_PER_FRAME + px];
          r.red_out   = dim(c[23:16]);
          r.green_out = dim(c[15:8]);
          r.blue_out  = dim(c[7:0]);
        end
      end
      default: begin
        // first advance of a run starts upward
        if (frame_now == 0 && loops_done == 0 && cfg_mode < lmap_pkg::MODE_RANDOM)
          going_down = 1'b0;
        if (loops_done >= cfg_loop_limit) begin
          loops_done   = '0;
          frame_now    = '0;
          going_down   = 1'b0;
          random_shows = '0;
        end else begin
          r.running     = 1'b1;
          r.shown_delay = delay_mem[frame_now[3:0]];
          case (cfg_mode)
            lmap_pkg::MODE_FORWARD: begin
              nf = frame_now + 5'd1;
              if (seq_end(nf)) begin
                nf = '0;
                bump_loop();
              end
              frame_now = nf;
            end
            lmap_pkg::MODE_PINGPONG: begin
              if (going_down) nf = (frame_now > 0) ? frame_now - 5'd1 : 5'd0;
              else nf = frame_now + 5'd1;
              // turn downward at the end, clamped at frame zero
              if (seq_end(nf)) begin
                going_down = 1'b1;
                nf = (nf >= 2) ? nf - 5'd2 : 5'd0;
                bump_loop();
              end
              if (nf == 0) begin
                going_down = 1'b0;
                bump_loop();
              end
              frame_now = nf;
            end
            lmap_pkg::MODE_RANDOM: begin
              random_shows++;
              for (int t = 0; t < TRIES; t++) begin
                lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                frame_now = {1'b0, lfsr[3:0]};
                if (delay_mem[lfsr[3:0]] != 16'd0) break;
              end
              if (random_shows >= lmap_pkg::SHOWS_PER_LOOP) begin
                random_shows = '0;
                bump_loop();
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    r.next_frame = frame_now[3:0];
    return r;
  endfunction

  function automatic logic [23:0] any_rgb();
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic logic [15:0] any_delay();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // predict and queue one command
  task automatic issue(input lmap_pkg::lmap_func_e f, input logic [3:0] fr,
                       input logic [3:0] col, input logic [3:0] row,
                       input logic [23:0] rgb, input logic [15:0] dly);
    player_cmd_t pc;
    pc.item.func        = f;
    pc.item.frame_index = fr;
    pc.item.column      = col;
    pc.item.row         = row;
    pc.item.red_in      = rgb[23:16];
    pc.item.green_in    = rgb[15:8];
    pc.item.blue_in     = rgb[7:0];
    pc.item.delay_in    = dly;
    pc.report = play_step(pc.item);
    cmd_queue.push_back(pc);
    queued_total++;
  endtask

  task automatic advance_cmd();
    issue(lmap_pkg::FUNC_ADVANCE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
          4'($urandom_range(0, 15)), any_rgb(), any_delay());
  endtask

  // pixel write, mostly inside the matrix
  task automatic put_pixel(input int fr);
    int col;
    int row;
    col = $urandom_range(0, COLS - 1);
    row = $urandom_range(0, ROWS - 1);
    if ($urandom_range(0, 9) == 0) begin
      col = $urandom_range(0, 15);
      row = $urandom_range(0, 15);
    end
    issue(lmap_pkg::FUNC_WR_PIXEL, 4'(fr), 4'(col), 4'(row), any_rgb(), any_delay());
  endtask

  // hold off until every queued command has reported
  task automatic wait_drained();
    while (reports_seen != queued_total) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write, mirrored in the software copy, then read back
  task automatic set_register(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd_want;
    rd_want = '0;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      lmap_pkg::REG_LOOP_LIMIT: begin
        cfg_loop_limit = val[7:0];
        rd_want = {24'd0, cfg_loop_limit};
      end
      lmap_pkg::REG_RUN_MODE: begin
        cfg_mode = lmap_pkg::lmap_mode_e'(val[1:0]);
        rd_want = {30'd0, cfg_mode};
      end
      lmap_pkg::REG_BRIGHTNESS: begin
        cfg_bright = val[7:0];
        rd_want = {24'd0, cfg_bright};
      end
      default: ;
    endcase
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx != REG_UNUSED && prdata !== rd_want) begin
      errors++;
      if (errors <= 10)
        $display("register %0d read back %0h, expected %0h", idx, prdata, rd_want);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // driver: offers queued commands at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || taken_q) begin
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        next_cmd = cmd_queue.pop_front();
        start          <= 1'b1;
        item_i         <= next_cmd.item;
        offered_report <= next_cmd.report;
        if ($urandom_range(1, 100) <= idle_pct) gap_left <= $urandom_range(1, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: records accepted commands and checks each report
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      taken_q <= start && !busy;
      if (result_valid_o) begin
        reports_seen <= reports_seen + 1;
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= 10) $display("report with no transaction pending at %0t", $realtime);
        end else begin
          want = expected_reports.pop_front();
          if (result_o.red_out !== want.red_out || result_o.green_out !== want.green_out ||
              result_o.blue_out !== want.blue_out || result_o.running !== want.running ||
              result_o.shown_delay !== want.shown_delay ||
              result_o.next_frame !== want.next_frame) begin
            errors++;
            if (errors <= 10) begin
              $write("mismatch at %0t (expected/actual): rgb %0h %0h %0h / %0h %0h %0h",
                     $realtime, want.red_out, want.green_out, want.blue_out,
                     result_o.red_out, result_o.green_out, result_o.blue_out);
              $display(" running %0d/%0d delay %0d/%0d frame %0d/%0d", want.running,
                       result_o.running, want.shown_delay, result_o.shown_delay,
                       want.next_frame, result_o.next_frame);
            end
          end
        end
      end
      if (start && !busy) expected_reports.push_back(offered_report);
      quiet_cycles <= (result_valid_o || (start && !busy)) ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    int                   phase;
    int                   seq_len;
    int                   n;
    int                   sel;
    int                   col;
    int                   row;
    int                   base;
    int                   off;
    bit                   found;
    bit                   squeeze;
    logic [7:0]           lim;
    logic [7:0]           bright;
    lmap_pkg::lmap_mode_e mode;

    for (int f = 0; f < FRAMES; f++) delay_mem[f] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: reset settings, empty delays, then edges of the matrix
    advance_cmd();
    advance_cmd();
    issue(lmap_pkg::FUNC_WR_PIXEL, 4'd0, 4'd0, 4'd0, 24'hFFFFFF, any_delay());
    issue(lmap_pkg::FUNC_WR_PIXEL, 4'd0, 4'd10, 4'd9, 24'h000000, any_delay());
    issue(lmap_pkg::FUNC_WR_PIXEL, 4'd0, 4'd11, 4'd0, any_rgb(), any_delay());
    issue(lmap_pkg::FUNC_WR_PIXEL, 4'd15, 4'd15, 4'd15, any_rgb(), any_delay());
    issue(lmap_pkg::FUNC_RD_PIXEL, 4'd15, 4'd0, 4'd0, any_rgb(), any_delay());
    issue(lmap_pkg::FUNC_RD_PIXEL, 4'd0, 4'd10, 4'd9, any_rgb(), any_delay());
    issue(lmap_pkg::FUNC_RD_PIXEL, 4'd0, 4'd11, 4'd0, any_rgb(), any_delay());
    issue(lmap_pkg::FUNC_RD_PIXEL, 4'd0, 4'd15, 4'd15, any_rgb(), any_delay());
    issue(lmap_pkg::FUNC_WR_DELAY, 4'd0, 4'd0, 4'd0, any_rgb(), 16'hFFFF);
    issue(lmap_pkg::FUNC_WR_DELAY, 4'd1, 4'd15, 4'd15, any_rgb(), 16'h0001);
    issue(lmap_pkg::FUNC_WR_DELAY, 4'd15, 4'd3, 4'd7, any_rgb(), 16'hFFFF);
    repeat (3) advance_cmd();

    // zero loop limit is done at once; zero brightness blanks the read
    wait_drained();
    set_register(lmap_pkg::REG_LOOP_LIMIT, 32'd0);
    set_register(lmap_pkg::REG_RUN_MODE, 32'(lmap_pkg::MODE_PINGPONG));
    set_register(lmap_pkg::REG_BRIGHTNESS, 32'd0);
    issue(lmap_pkg::FUNC_RD_PIXEL, 4'd0, 4'd0, 4'd0, any_rgb(), any_delay());
    advance_cmd();

    // ping-pong turn with the longest loop limit
    wait_drained();
    set_register(lmap_pkg::REG_LOOP_LIMIT, 32'd255);
    set_register(lmap_pkg::REG_BRIGHTNESS, 32'h80);
    set_register(REG_UNUSED, 32'hFFFF_FFFF);
    repeat (3) advance_cmd();

    wait_drained();
    set_register(lmap_pkg::REG_RUN_MODE, 32'(lmap_pkg::MODE_RANDOM));
    repeat (3) advance_cmd();

    wait_drained();
    set_register(lmap_pkg::REG_RUN_MODE, 32'(lmap_pkg::MODE_HOLD));
    repeat (2) advance_cmd();

    // random phases: settings, a frame sequence, then mixed commands
    phase = 0;
    while (queued_total < ITEM_TARGET) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       lim = 8'd0;
        1:       lim = 8'd255;
        2, 3:    lim = 8'($urandom_range(1, 3));
        default: lim = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0:       bright = 8'd0;
        1:       bright = 8'd255;
        default: bright = 8'($urandom_range(0, 255));
      endcase
      mode = ($urandom_range(0, 9) == 0) ? lmap_pkg::MODE_HOLD :
             lmap_pkg::lmap_mode_e'($urandom_range(0, 2));
      set_register(lmap_pkg::REG_LOOP_LIMIT, 32'(lim));
      set_register(lmap_pkg::REG_RUN_MODE, 32'(mode));
      set_register(lmap_pkg::REG_BRIGHTNESS, 32'(bright));
      if ($urandom_range(0, 7) == 0) set_register(REG_UNUSED, $urandom);

      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      if (queued_total >= CALM_FROM) idle_pct = 0;
      squeeze = (phase == 0) || ($urandom_range(0, 3) == 0);

      // well-formed sequence of nonzero delays, ended by a zero unless it fills every frame, or noise
      seq_len = $urandom_range(1, FRAMES);
      if ($urandom_range(0, 4) != 0) begin
        for (int f = 0; f < seq_len; f++)
          issue(lmap_pkg::FUNC_WR_DELAY, 4'(f), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), any_rgb(), 16'($urandom_range(1, 16'hFFFF)));
        if (seq_len < FRAMES)
          issue(lmap_pkg::FUNC_WR_DELAY, 4'(seq_len), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), any_rgb(), 16'd0);
      end else begin
        repeat (3)
          issue(lmap_pkg::FUNC_WR_DELAY, 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), any_rgb(),
                ($urandom_range(0, 1) == 0) ? 16'd0 : any_delay());
      end
      repeat ($urandom_range(4, 12)) put_pixel($urandom_range(0, seq_len - 1));

      n = $urandom_range(30, 70);
      for (int k = 0; k < n; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          advance_cmd();
        end else if (sel < 75) begin
          // read pixels already written in the frame shown now, or an out-of-matrix position
          col = $urandom_range(0, COLS - 1);
          row = $urandom_range(0, ROWS - 1);
          if ($urandom_range(0, 9) == 0) begin
            col = $urandom_range(0, 15);
            row = $urandom_range(0, 15);
          end
          if (col < COLS && row < ROWS &&
              !pixel_set[frame_now * PIX_PER_FRAME + row * COLS + col]) begin
            base  = $urandom_range(0, PIX_PER_FRAME - 1);
            found = 1'b0;
            for (int s = 0; s < PIX_PER_FRAME && !found; s++) begin
              off = (base + s) % PIX_PER_FRAME;
              if (pixel_set[frame_now * PIX_PER_FRAME + off]) begin
                found = 1'b1;
                col   = off % COLS;
                row   = off / COLS;
              end
            end
            if (!found) col = $urandom_range(COLS, 15);
          end
          issue(lmap_pkg::FUNC_RD_PIXEL, 4'($urandom_range(0, 15)), 4'(col), 4'(row),
                any_rgb(), any_delay());
        end else if (sel < 92) begin
          put_pixel(($urandom_range(0, 9) < 7) ? $urandom_range(0, seq_len - 1) :
                    $urandom_range(0, 15));
        end else begin
          issue(lmap_pkg::FUNC_WR_DELAY, 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), any_rgb(),
                ($urandom_range(0, 3) == 0) ? 16'd0 : any_delay());
        end
        // sender stops until every outstanding transaction has reported
        if (squeeze && k == n / 2) wait_drained();
      end
      phase++;
    end

    // drain and settle
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (expected_reports.size() != 0) errors++;
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lmap_pkg.sv
src/lmap_regs.sv
src/lmap_pixel_mem.sv
src/lmap_delay_mem.sv
src/lmap_scaler.sv
src/led_matrix_animation_player.sv
test/testbench.sv
